// ----- rtl/smx_pkg.sv -----
// ----------------------------------------------------------------------------
// smx_pkg
// Types, opcode codes and decode helpers of the stack machine execute unit.
// ----------------------------------------------------------------------------
package smx_pkg;

    typedef enum logic [4:0] {
        OP_NOP    = 5'd0,
        OP_HALT   = 5'd1,
        OP_SET    = 5'd2,
        OP_SETZ   = 5'd3,
        OP_ADD    = 5'd4,
        OP_SUB    = 5'd5,
        OP_MUL    = 5'd6,
        OP_INC    = 5'd7,
        OP_DEC    = 5'd8,
        OP_LT     = 5'd9,
        OP_EQ     = 5'd10,
        OP_EQZ    = 5'd11,
        OP_JP     = 5'd12,
        OP_JPNZ   = 5'd13,
        OP_JPZ    = 5'd14,
        OP_LOAD   = 5'd15,
        OP_STORE  = 5'd16,
        OP_DROP   = 5'd17,
        OP_SWAP   = 5'd18,
        OP_TWODUP = 5'd19,
        OP_ROT    = 5'd20,
        OP_DUP    = 5'd21,
        OP_OVER   = 5'd22,
        OP_PRINT  = 5'd23
    } t_opcode;

    typedef enum logic [1:0] {
        FLT_NONE  = 2'd0,
        FLT_OVER  = 2'd1,
        FLT_UNDER = 2'd2,
        FLT_ADDR  = 2'd3
    } t_fault;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CAP,
        ST_EXEC,
        ST_WRITE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0] pops;
        logic [2:0] pushes;
        logic       len2;
    } t_dec;

    function automatic t_dec decode(input t_opcode op);
        t_dec d;
        d = '{pops: 2'd0, pushes: 3'd0, len2: 1'b0};
        case (op)
            OP_SET, OP_LOAD: begin
                d.pushes = 3'd1;
                d.len2   = 1'b1;
            end
            OP_SETZ: d.pushes = 3'd1;
            OP_ADD, OP_SUB, OP_MUL, OP_LT, OP_EQ: begin
                d.pops   = 2'd2;
                d.pushes = 3'd1;
            end
            OP_INC, OP_DEC, OP_EQZ: begin
                d.pops   = 2'd1;
                d.pushes = 3'd1;
            end
            OP_JP: d.len2 = 1'b1;
            OP_JPNZ, OP_JPZ, OP_STORE: begin
                d.pops = 2'd1;
                d.len2 = 1'b1;
            end
            OP_DROP, OP_PRINT: d.pops = 2'd1;
            OP_SWAP: begin
                d.pops   = 2'd2;
                d.pushes = 3'd2;
            end
            OP_TWODUP: begin
                d.pops   = 2'd2;
                d.pushes = 3'd4;
            end
            OP_ROT: begin
                d.pops   = 2'd3;
                d.pushes = 3'd3;
            end
            OP_DUP: begin
                d.pops   = 2'd1;
                d.pushes = 3'd2;
            end
            OP_OVER: begin
                d.pops   = 2'd2;
                d.pushes = 3'd3;
            end
            default: d = '{pops: 2'd0, pushes: 3'd0, len2: 1'b0};
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/smx_ram.sv -----
// ----------------------------------------------------------------------------
// smx_ram
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module smx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/stack_machine_execute_unit_core.sv -----
// ----------------------------------------------------------------------------
// stack_machine_execute_unit_core
// Execute unit of a 32-bit stack virtual machine with memory-held stack and
// variable store.
// ----------------------------------------------------------------------------
// An instruction beat is buffered on arrival, so the next beat can be taken
// while the current one executes. Execution is sequenced over the single
// read port and single write port of the stack memory: a decode step, a read
// and a capture step for each stack value popped (or for the variable read of
// LOAD), a compute step, a write step for each value pushed and a step that
// hands the result to the output register; a faulting or ignored instruction
// goes straight from decode to that hand-over step.
module stack_machine_execute_unit_core
    import smx_pkg::*;
#(
    parameter int STACK_DEPTH = 256,
    parameter int VAR_DEPTH   = 256,
    parameter int PC_BITS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [4:0]  i_opcode,
    input  logic signed [31:0] i_operand,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_next_pc,
    output logic        o_print_valid,
    output logic signed [31:0] o_print_value,
    output logic        o_halted,
    output logic [1:0]  o_fault,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int VAW = (VAR_DEPTH > 1) ? $clog2(VAR_DEPTH) : 1;
    localparam int CW  = $clog2(STACK_DEPTH + 1);

    t_state r_state, n_state;

    logic              r_in_valid;
    logic [4:0]        r_in_op;
    logic [31:0]       r_in_opnd;
    t_opcode           r_op;
    logic [31:0]       r_opnd;
    t_dec              r_dec;
    logic [CW-1:0]     r_base;
    logic [CW-1:0]     r_count;
    logic [2:0]        r_k;
    logic [31:0]       r_s [3];
    logic [31:0]       r_r [4];
    logic [PC_BITS-1:0] r_pc;
    logic              r_halt;

    logic [PC_BITS-1:0] r_res_pc;
    logic              r_res_pv;
    logic [31:0]       r_res_val;
    logic              r_res_halt;
    t_fault            r_res_fault;

    logic              r_out_valid;
    logic [PC_BITS-1:0] r_out_pc;
    logic              r_out_pv;
    logic [31:0]       r_out_val;
    logic              r_out_halt;
    t_fault            r_out_fault;

    t_opcode           w_op;
    t_dec              w_dec;
    logic              w_addr_ok;
    logic              w_unf;
    logic              w_ovf;
    t_fault            w_fault;
    logic [CW+1:0]     w_after;
    logic [2:0]        w_nread;
    logic              w_out_free;

    logic              w_stk_we;
    logic [SAW-1:0]    w_stk_waddr;
    logic [SAW-1:0]    w_stk_raddr;
    logic [31:0]       w_stk_q;
    logic              w_var_we;
    logic [VAW-1:0]    w_var_addr;
    logic [31:0]       w_var_q;

    logic [31:0]       w_res0;
    logic [PC_BITS-1:0] w_next_pc;
    logic [PC_BITS-1:0] w_target;

    assign o_ready    = !r_in_valid;
    assign w_out_free = !r_out_valid || i_ready;

    assign w_op      = t_opcode'(r_in_op);
    assign w_dec     = decode(w_op);
    assign w_addr_ok = !r_in_opnd[31] && (r_in_opnd < 32'(VAR_DEPTH));
    assign w_unf     = r_count < CW'(w_dec.pops);
    assign w_after   = (CW+2)'(r_count) + (CW+2)'(w_dec.pushes) - (CW+2)'(w_dec.pops);
    assign w_ovf     = w_after > (CW+2)'(STACK_DEPTH);

    always_comb begin
        if (w_op == OP_LOAD) begin
            w_fault = !w_addr_ok ? FLT_ADDR : (w_ovf ? FLT_OVER : FLT_NONE);
        end else if (w_op == OP_STORE) begin
            w_fault = w_unf ? FLT_UNDER : (!w_addr_ok ? FLT_ADDR : FLT_NONE);
        end else begin
            w_fault = w_unf ? FLT_UNDER : (w_ovf ? FLT_OVER : FLT_NONE);
        end
    end

    assign w_nread = (r_op == OP_LOAD) ? 3'd1 : 3'(r_dec.pops);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (r_in_valid) begin
                    if (r_halt || w_fault != FLT_NONE) begin
                        n_state = ST_DONE;
                    end else if (w_dec.pops != 2'd0 || w_op == OP_LOAD) begin
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_READ: n_state = ST_CAP;
            ST_CAP: begin
                n_state = (r_k + 3'd1 < w_nread) ? ST_READ : ST_EXEC;
            end
            ST_EXEC: begin
                n_state = (r_dec.pushes != 3'd0) ? ST_WRITE : ST_DONE;
            end
            ST_WRITE: begin
                n_state = (r_k + 3'd1 == r_dec.pushes) ? ST_DONE : ST_WRITE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_stk_we    = 1'b0;
        w_var_we    = 1'b0;
        w_stk_waddr = SAW'(r_base + CW'(r_k));
        w_stk_raddr = SAW'(r_base + CW'(r_k));
        w_var_addr  = VAW'(r_opnd);
        case (r_state)
            ST_EXEC:  w_var_we = (r_op == OP_STORE);
            ST_WRITE: w_stk_we = 1'b1;
            default: begin
                w_stk_we = 1'b0;
                w_var_we = 1'b0;
            end
        endcase
    end

    assign w_target = PC_BITS'(r_opnd);

    always_comb begin
        w_next_pc = r_pc + (r_dec.len2 ? PC_BITS'(2) : PC_BITS'(1));
        w_res0    = '0;
        case (r_op)
            OP_SET:   w_res0 = r_opnd;
            OP_ADD:   w_res0 = r_s[0] + r_s[1];
            OP_SUB:   w_res0 = r_s[0] - r_s[1];
            OP_MUL:   w_res0 = r_s[0] * r_s[1];
            OP_INC:   w_res0 = r_s[0] + 32'd1;
            OP_DEC:   w_res0 = r_s[0] - 32'd1;
            OP_LT:    w_res0 = 32'($signed(r_s[0]) < $signed(r_s[1]));
            OP_EQ:    w_res0 = 32'(r_s[0] == r_s[1]);
            OP_EQZ:   w_res0 = 32'(r_s[0] == 32'd0);
            OP_LOAD:  w_res0 = r_s[0];
            OP_SWAP:  w_res0 = r_s[1];
            OP_ROT:   w_res0 = r_s[1];
            OP_TWODUP, OP_DUP, OP_OVER: w_res0 = r_s[0];
            OP_JP:    w_next_pc = w_target;
            OP_JPNZ: begin
                if (r_s[0] != 32'd0) begin
                    w_next_pc = w_target;
                end
            end
            OP_JPZ: begin
                if (r_s[0] == 32'd0) begin
                    w_next_pc = w_target;
                end
            end
            default: w_res0 = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_valid  <= 1'b0;
            r_count     <= '0;
            r_pc        <= '0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (r_state == ST_IDLE) begin
                r_in_valid <= 1'b0;
            end
            if (r_state == ST_EXEC) begin
                r_count <= r_base + CW'(r_dec.pushes);
                r_pc    <= w_next_pc;
                if (r_op == OP_HALT) begin
                    r_halt <= 1'b1;
                end
            end else if (i_cfg_we) begin
                r_pc <= PC_BITS'(i_cfg_data);
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_op   <= i_opcode;
            r_in_opnd <= i_operand;
        end
        case (r_state)
            ST_IDLE: begin
                r_op        <= w_op;
                r_opnd      <= r_in_opnd;
                r_dec       <= w_dec;
                r_base      <= r_count - CW'(w_dec.pops);
                r_k         <= 3'd0;
                r_res_pc    <= r_pc;
                r_res_pv    <= 1'b0;
                r_res_val   <= '0;
                r_res_halt  <= r_halt;
                r_res_fault <= r_halt ? FLT_NONE : w_fault;
            end
            ST_CAP: begin
                r_s[r_k[1:0]] <= (r_op == OP_LOAD) ? w_var_q : w_stk_q;
                r_k           <= r_k + 3'd1;
            end
            ST_EXEC: begin
                r_r[0]     <= w_res0;
                r_r[1]     <= (r_op == OP_ROT) ? r_s[2] :
                              ((r_op == OP_OVER || r_op == OP_TWODUP) ? r_s[1] : r_s[0]);
                r_r[2]     <= r_s[0];
                r_r[3]     <= r_s[1];
                r_k        <= 3'd0;
                r_res_pc   <= w_next_pc;
                r_res_pv   <= (r_op == OP_PRINT);
                r_res_val  <= (r_op == OP_PRINT) ? r_s[0] : 32'd0;
                r_res_halt <= (r_op == OP_HALT);
            end
            ST_WRITE: r_k <= r_k + 3'd1;
            ST_DONE: begin
                if (w_out_free) begin
                    r_out_pc    <= r_res_pc;
                    r_out_pv    <= r_res_pv;
                    r_out_val   <= r_res_val;
                    r_out_halt  <= r_res_halt;
                    r_out_fault <= r_res_fault;
                end
            end
            default: r_k <= r_k;
        endcase
    end

    smx_ram #(
        .WIDTH(32),
        .DEPTH(STACK_DEPTH),
        .AW   (SAW)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (w_stk_we),
        .i_waddr(w_stk_waddr),
        .i_wdata(r_r[r_k[1:0]]),
        .i_raddr(w_stk_raddr),
        .o_rdata(w_stk_q)
    );

    smx_ram #(
        .WIDTH(32),
        .DEPTH(VAR_DEPTH),
        .AW   (VAW)
    ) u_vars (
        .i_clk  (i_clk),
        .i_we   (w_var_we),
        .i_waddr(w_var_addr),
        .i_wdata(r_s[0]),
        .i_raddr(w_var_addr),
        .o_rdata(w_var_q)
    );

    assign o_valid       = r_out_valid;
    assign o_next_pc     = 16'(r_out_pc);
    assign o_print_valid = r_out_pv;
    assign o_print_value = r_out_val;
    assign o_halted      = r_out_halt;
    assign o_fault       = r_out_fault;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared");
    a_fault_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fault != FLT_NONE) |-> !r_out_pv)
        else $error("print on faulting beat");
    a_no_mem_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_DONE) |-> !(w_stk_we || w_var_we))
        else $error("memory write outside execution");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the stack machine execute unit.
// ----------------------------------------------------------------------------
// A directed table covers stack underflow, address faults, value extremes and
// every stack operation. Random instruction streams then push the stack
// between shallow and full depth under four idling patterns, with start_pc
// rewritten between phases. The run ends with HALT and a few ignored beats.
// Each result beat is checked against a local model or the table's own outcome.
// ----------------------------------------------------------------------------
module tb;
    import smx_pkg::*;

    localparam int DEPTH     = 256;
    localparam int VARS      = 256;
    localparam int LIMIT     = 600000;
    localparam int PHASE_LEN = 400;

    typedef struct {
        logic [15:0] pc;
        logic        pvalid;
        logic [31:0] pvalue;
        logic        halted;
        t_fault      fault;
    } t_outcome;

    typedef struct {
        t_opcode     op;
        logic [31:0] opnd;
        logic        typed;
        logic [15:0] pc;
        t_fault      fault;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [4:0]  i_opcode = '0;
    logic signed [31:0] i_operand = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_next_pc;
    logic        o_print_valid;
    logic signed [31:0] o_print_value;
    logic        o_halted;
    logic [1:0]  o_fault;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;

    // Shadow machine state.
    logic [31:0] stk [DEPTH];
    logic [31:0] vars [VARS];
    bit          var_set [VARS];
    int          depth_now;
    logic [15:0] pc_now;
    logic        halt_now;

    t_outcome    pending [$];
    int          idle_mode;
    int          cycles;
    bit          failed;

    stack_machine_execute_unit_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_operand     (i_operand),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_next_pc     (o_next_pc),
        .o_print_valid (o_print_valid),
        .o_print_value (o_print_value),
        .o_halted      (o_halted),
        .o_fault       (o_fault),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        case (idle_mode)
            2:       i_ready <= ($urandom_range(99) >= 78);
            3:       i_ready <= ($urandom_range(99) >= 33);
            default: i_ready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending.size() == 0) begin
                $error("result beat with no expectation pending");
                failed = 1'b1;
            end else begin
                e = pending.pop_front();
                if (o_next_pc !== e.pc) begin
                    $error("next_pc expected %h actual %h", e.pc, o_next_pc);
                    failed = 1'b1;
                end
                if (o_print_valid !== e.pvalid) begin
                    $error("print_valid expected %b actual %b", e.pvalid, o_print_valid);
                    failed = 1'b1;
                end
                if (o_print_value !== e.pvalue) begin
                    $error("print_value expected %h actual %h", e.pvalue, o_print_value);
                    failed = 1'b1;
                end
                if (o_halted !== e.halted) begin
                    $error("halted expected %b actual %b", e.halted, o_halted);
                    failed = 1'b1;
                end
                if (o_fault !== e.fault) begin
                    $error("fault expected %0d actual %0d", e.fault, o_fault);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic execute_instr(input logic [4:0] op, input logic [31:0] opnd,
                                 output t_outcome e);
        int          pops;
        int          pushes;
        int          len;
        int          base;
        bit          addr_ok;
        logic [31:0] s [3];
        logic [31:0] r [4];
        logic [15:0] nxt;
        e = '{pc: pc_now, pvalid: 1'b0, pvalue: '0, halted: halt_now, fault: FLT_NONE};
        if (halt_now) return;
        pops = 0;
        pushes = 0;
        len = 1;
        case (t_opcode'(op))
            OP_SET, OP_LOAD: begin pushes = 1; len = 2; end
            OP_SETZ: pushes = 1;
            OP_ADD, OP_SUB, OP_MUL, OP_LT, OP_EQ: begin pops = 2; pushes = 1; end
            OP_INC, OP_DEC, OP_EQZ: begin pops = 1; pushes = 1; end
            OP_JP: len = 2;
            OP_JPNZ, OP_JPZ, OP_STORE: begin pops = 1; len = 2; end
            OP_DROP, OP_PRINT: pops = 1;
            OP_SWAP: begin pops = 2; pushes = 2; end
            OP_TWODUP: begin pops = 2; pushes = 4; end
            OP_ROT: begin pops = 3; pushes = 3; end
            OP_DUP: begin pops = 1; pushes = 2; end
            OP_OVER: begin pops = 2; pushes = 3; end
            default: ;
        endcase
        addr_ok = !opnd[31] && (opnd < VARS);
        if (op == OP_LOAD) begin
            if (!addr_ok) e.fault = FLT_ADDR;
            else if (depth_now + 1 > DEPTH) e.fault = FLT_OVER;
        end else if (op == OP_STORE) begin
            if (depth_now < 1) e.fault = FLT_UNDER;
            else if (!addr_ok) e.fault = FLT_ADDR;
        end else if (depth_now < pops) begin
            e.fault = FLT_UNDER;
        end else if (depth_now - pops + pushes > DEPTH) begin
            e.fault = FLT_OVER;
        end
        if (e.fault != FLT_NONE) return;
        base = depth_now - pops;
        for (int i = 0; i < 3; i++) s[i] = (i < pops) ? stk[base + i] : '0;
        for (int i = 0; i < 4; i++) r[i] = '0;
        nxt = pc_now + 16'(len);
        case (t_opcode'(op))
            OP_HALT:   halt_now = 1'b1;
            OP_SET:    r[0] = opnd;
            OP_ADD:    r[0] = s[0] + s[1];
            OP_SUB:    r[0] = s[0] - s[1];
            OP_MUL:    r[0] = s[0] * s[1];
            OP_INC:    r[0] = s[0] + 1;
            OP_DEC:    r[0] = s[0] - 1;
            OP_LT:     r[0] = ($signed(s[0]) < $signed(s[1])) ? 32'd1 : 32'd0;
            OP_EQ:     r[0] = (s[0] == s[1]) ? 32'd1 : 32'd0;
            OP_EQZ:    r[0] = (s[0] == 0) ? 32'd1 : 32'd0;
            OP_JP:     nxt = opnd[15:0];
            OP_JPNZ:   if (s[0] != 0) nxt = opnd[15:0];
            OP_JPZ:    if (s[0] == 0) nxt = opnd[15:0];
            OP_LOAD:   r[0] = vars[opnd[7:0]];
            OP_STORE: begin
                vars[opnd[7:0]] = s[0];
                var_set[opnd[7:0]] = 1'b1;
            end
            OP_SWAP:   begin r[0] = s[1]; r[1] = s[0]; end
            OP_TWODUP: begin r[0] = s[0]; r[1] = s[1]; r[2] = s[0]; r[3] = s[1]; end
            OP_ROT:    begin r[0] = s[1]; r[1] = s[2]; r[2] = s[0]; end
            OP_DUP:    begin r[0] = s[0]; r[1] = s[0]; end
            OP_OVER:   begin r[0] = s[0]; r[1] = s[1]; r[2] = s[0]; end
            OP_PRINT:  begin e.pvalid = 1'b1; e.pvalue = s[0]; end
            default: ;
        endcase
        for (int i = 0; i < pushes; i++) stk[base + i] = r[i];
        depth_now = base + pushes;
        pc_now = nxt;
        e.pc = nxt;
        e.halted = halt_now;
    endtask

    task automatic send_beat(input logic [4:0] op, input logic [31:0] opnd,
                             input bit typed, input t_outcome typed_exp);
        t_outcome e;
        int       pct;
        pct = (idle_mode == 1) ? 78 : (idle_mode == 3) ? 33 : 0;
        if (pct != 0 && $urandom_range(99) < pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < pct);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_operand <= opnd;
        do @(posedge i_clk); while (!o_ready);
        execute_instr(op, opnd, e);
        pending.push_back(typed ? typed_exp : e);
    endtask

    task automatic wait_drained();
        while (pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_start_pc(input logic [15:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pc_now = value;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_addr(input bit for_load);
        int k;
        if ($urandom_range(99) < 12) begin
            case ($urandom_range(2))
                0:       return 32'hFFFF_FFFF;
                1:       return VARS;
                default: return $urandom | 32'h0000_0100;
            endcase
        end
        if (!for_load) return $urandom_range(VARS - 1);
        k = $urandom_range(VARS - 1);
        for (int i = 0; i < VARS; i++) begin
            if (var_set[(k + i) % VARS]) return (k + i) % VARS;
        end
        return VARS;
    endfunction

    task automatic random_beat(input int goal);
        logic [4:0]  op;
        logic [31:0] opnd;
        t_outcome    none;
        none = '{pc: '0, pvalid: 1'b0, pvalue: '0, halted: 1'b0, fault: FLT_NONE};
        if ($urandom_range(99) < 6) begin
            op = 5'($urandom_range(24, 31));
        end else if (depth_now < goal && $urandom_range(99) < 55) begin
            case ($urandom_range(5))
                0:       op = OP_SETZ;
                1:       op = OP_LOAD;
                2:       op = OP_DUP;
                3:       op = OP_TWODUP;
                4:       op = OP_OVER;
                default: op = OP_SET;
            endcase
        end else begin
            do op = 5'($urandom_range(0, 23)); while (op == OP_HALT);
        end
        case (t_opcode'(op))
            OP_SET:             opnd = pick_value();
            OP_LOAD:            opnd = pick_addr(1'b1);
            OP_STORE:           opnd = pick_addr(1'b0);
            OP_JP, OP_JPNZ, OP_JPZ:
                                opnd = ($urandom_range(3) == 0) ? $urandom : $urandom_range(65535);
            default:            opnd = $urandom;
        endcase
        send_beat(op, opnd, 1'b0, none);
    endtask

    t_row     rows [$];
    t_outcome typed_exp;
    int       goal;

    function automatic t_row mk(input t_opcode op, input logic [31:0] opnd,
                                input logic typed, input logic [15:0] pc,
                                input t_fault fault);
        t_row r;
        r = '{op: op, opnd: opnd, typed: typed, pc: pc, fault: fault};
        return r;
    endfunction

    initial begin
        cycles = 0;
        failed = 1'b0;
        idle_mode = 0;
        depth_now = 0;
        pc_now = '0;
        halt_now = 1'b0;
        for (int i = 0; i < VARS; i++) var_set[i] = 1'b0;

        rows.push_back(mk(OP_DROP,   32'd0,          1, 16'd0,      FLT_UNDER));
        rows.push_back(mk(OP_STORE,  32'd0,          1, 16'd0,      FLT_UNDER));
        rows.push_back(mk(OP_LOAD,   32'hFFFF_FFFF,  1, 16'd0,      FLT_ADDR));
        rows.push_back(mk(OP_LOAD,   32'd256,        1, 16'd0,      FLT_ADDR));
        rows.push_back(mk(OP_SET,    32'h7FFF_FFFF,  1, 16'd2,      FLT_NONE));
        rows.push_back(mk(OP_SET,    32'h8000_0000,  1, 16'd4,      FLT_NONE));
        rows.push_back(mk(OP_LT,     32'd0,          0, 16'd0,      FLT_NONE));
        rows.push_back(mk(OP_SET,    32'hFFFF_FFFF,  0, 16'd0,      FLT_NONE));
        rows.push_back(mk(OP_MUL,    32'd0,          0, 16'd0,      FLT_NONE));
        rows.push_back(mk(OP_SETZ,   32'd0,          0, 16'd0,      FLT_NONE));
        rows.push_back(mk(OP_EQZ,    32'd0,          0, 16'd0,      FLT_NONE));
        rows.push_back(mk(OP_INC,    32'd0,          0, 16'd0,      FLT_NONE));
        rows.push_back(mk(OP_DUP,    32'd0,          0, 16'd0,      FLT_NONE));
        rows.push_back(mk(OP_OVER,   32'd0,          0, 16'd0,      FLT_NONE));
        rows.push_back(mk(OP_ROT,    32'd0,          0, 16'd0,      FLT_NONE));
        rows.push_back(mk(OP_TWODUP, 32'd0,          0, 16'd0,      FLT_NONE));
        rows.push_back(mk(OP_SWAP,   32'd0,          0, 16'd0,      FLT_NONE));
        rows.push_back(mk(OP_EQ,     32'd0,          0, 16'd0,      FLT_NONE));
        rows.push_back(mk(OP_SUB,    32'd0,          0, 16'd0,      FLT_NONE));
        rows.push_back(mk(OP_DEC,    32'd0,          0, 16'd0,      FLT_NONE));
        rows.push_back(mk(OP_STORE,  32'd255,        0, 16'd0,      FLT_NONE));
        rows.push_back(mk(OP_LOAD,   32'd255,        0, 16'd0,      FLT_NONE));
        rows.push_back(mk(OP_PRINT,  32'd0,          0, 16'd0,      FLT_NONE));
        rows.push_back(mk(OP_JPNZ,   32'h0001_2345,  0, 16'd0,      FLT_NONE));
        rows.push_back(mk(OP_ADD,    32'd0,          0, 16'd0,      FLT_NONE));
        rows.push_back(mk(OP_JPZ,    32'd0,          0, 16'd0,      FLT_NONE));
        rows.push_back(mk(OP_JP,     32'h0000_FFFF,  0, 16'd0,      FLT_NONE));
        rows.push_back(mk(t_opcode'(5'd31), 32'd0,   0, 16'd0,      FLT_NONE));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            typed_exp = '{pc: rows[i].pc, pvalid: 1'b0, pvalue: '0, halted: 1'b0,
                          fault: rows[i].fault};
            send_beat(rows[i].op, rows[i].opnd, rows[i].typed, typed_exp);
        end

        for (int ph = 0; ph < 4; ph++) begin
            i_valid <= 1'b0;
            wait_drained();
            idle_mode = ph;
            case (ph)
                0:       write_start_pc(16'hFFFF);
                1:       write_start_pc(16'h0000);
                2:       write_start_pc(16'($urandom));
                default: write_start_pc(16'h8000);
            endcase
            goal = (ph == 0) ? DEPTH + 2 : 8;
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (n % 50 == 49) begin
                    case ($urandom_range(3))
                        0:       goal = 2;
                        1:       goal = 8;
                        2:       goal = 40;
                        default: goal = DEPTH + 2;
                    endcase
                end
                if (ph == 1 && n == PHASE_LEN / 2) begin
                    i_valid <= 1'b0;
                    while (pending.size() != 0) @(posedge i_clk);
                end
                random_beat(goal);
            end
        end

        typed_exp = '{pc: '0, pvalid: 1'b0, pvalue: '0, halted: 1'b0, fault: FLT_NONE};
        send_beat(OP_HALT, $urandom, 1'b0, typed_exp);
        for (int n = 0; n < 6; n++) random_beat(8);
        i_valid <= 1'b0;
        wait_drained();

        if (!failed) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- stack_machine_execute_unit_core.f -----
rtl/smx_pkg.sv
rtl/smx_ram.sv
rtl/stack_machine_execute_unit_core.sv
tb/sv/tb.sv
